@@ hdl/atm_pkg.sv @@
// ----------------------------------------------------------------------------
// Axis tolerance time monitor package
// Shared widths, register indexes, payload structs and the saturating
// magnitude function.
// ----------------------------------------------------------------------------
package atm_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int MAG_W       = VALUE_WIDTH - 1;
	localparam int TOL_W       = 31;
	localparam int CMP_W       = (MAG_W > TOL_W) ? MAG_W : TOL_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 31;

	// Bit positions inside monitor_enables.
	localparam int EN_IN_POS    = 0;
	localparam int EN_LAG       = 1;
	localparam int EN_OVERSPEED = 2;

	// Reset values of the configuration registers.
	localparam logic [2:0]  ENABLES_RST     = 3'd3;
	localparam logic [15:0] OS_TRAJ_DLY_RST = 16'd200;
	localparam logic [15:0] OS_DRV_DLY_RST  = 16'd400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MONITOR_ENABLES       = 3'd0,
		REG_IN_POSITION_TOLERANCE = 3'd1,
		REG_IN_POSITION_CYCLES    = 3'd2,
		REG_LAG_TOLERANCE         = 3'd3,
		REG_LAG_CYCLES            = 3'd4,
		REG_VELOCITY_LIMIT        = 3'd5,
		REG_OVERSPEED_TRAJ_DELAY  = 3'd6,
		REG_OVERSPEED_DRIVE_DELAY = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]       monitor_enables;
		logic [TOL_W-1:0] in_position_tolerance;
		logic [15:0]      in_position_cycles;
		logic [TOL_W-1:0] lag_tolerance;
		logic [14:0]      lag_cycles;
		logic [TOL_W-1:0] velocity_limit;
		logic [15:0]      overspeed_traj_delay;
		logic [15:0]      overspeed_drive_delay;
	} cfg_t;

	typedef struct packed {
		logic                          clear_monitor;
		logic                          axis_enabled;
		logic                          axis_enabled_prev;
		logic signed [VALUE_WIDTH-1:0] control_error;
		logic signed [VALUE_WIDTH-1:0] target_position_wrapped;
		logic signed [VALUE_WIDTH-1:0] position_setpoint;
		logic signed [VALUE_WIDTH-1:0] velocity_actual;
		logic signed [VALUE_WIDTH-1:0] velocity_setpoint;
	} tick_t;

	typedef struct packed {
		logic in_position;
		logic lag_traj_interlock;
		logic lag_drive_interlock;
		logic overspeed_traj_interlock;
		logic overspeed_drive_interlock;
	} result_t;

	// Absolute value; the most negative code saturates to the largest positive one.
	function automatic logic [MAG_W-1:0] magnitude(input logic [VALUE_WIDTH-1:0] v);
		logic [VALUE_WIDTH-1:0] neg;
		logic [MAG_W-1:0]       mag;
		neg = -v;
		if (!v[VALUE_WIDTH-1]) begin
			mag = v[MAG_W-1:0];
		end else if (neg[VALUE_WIDTH-1]) begin
			mag = '1;
		end else begin
			mag = neg[MAG_W-1:0];
		end
		return mag;
	endfunction

endpackage

@@ hdl/atm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Axis tolerance time monitor configuration registers
// Holds the eight monitor settings, written through a plain write port.
// ----------------------------------------------------------------------------
module atm_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [atm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [atm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output atm_pkg::cfg_t                    cfg
);

	atm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q                       <= '0;
			cfg_q.monitor_enables       <= atm_pkg::ENABLES_RST;
			cfg_q.overspeed_traj_delay  <= atm_pkg::OS_TRAJ_DLY_RST;
			cfg_q.overspeed_drive_delay <= atm_pkg::OS_DRV_DLY_RST;
		end else if (cfg_we) begin
			case (atm_pkg::cfg_reg_t'(cfg_index))
				atm_pkg::REG_MONITOR_ENABLES: begin
					cfg_q.monitor_enables <= cfg_data[2:0];
				end
				atm_pkg::REG_IN_POSITION_TOLERANCE: begin
					cfg_q.in_position_tolerance <= cfg_data[atm_pkg::TOL_W-1:0];
				end
				atm_pkg::REG_IN_POSITION_CYCLES: begin
					cfg_q.in_position_cycles <= cfg_data[15:0];
				end
				atm_pkg::REG_LAG_TOLERANCE: begin
					cfg_q.lag_tolerance <= cfg_data[atm_pkg::TOL_W-1:0];
				end
				atm_pkg::REG_LAG_CYCLES: begin
					cfg_q.lag_cycles <= cfg_data[14:0];
				end
				atm_pkg::REG_VELOCITY_LIMIT: begin
					cfg_q.velocity_limit <= cfg_data[atm_pkg::TOL_W-1:0];
				end
				atm_pkg::REG_OVERSPEED_TRAJ_DELAY: begin
					cfg_q.overspeed_traj_delay <= cfg_data[15:0];
				end
				atm_pkg::REG_OVERSPEED_DRIVE_DELAY: begin
					cfg_q.overspeed_drive_delay <= cfg_data[15:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/atm_monitor.sv @@
// ----------------------------------------------------------------------------
// Axis tolerance time monitor core
// Holds the monitor counters and the overspeed latch and evaluates one tick
// per step: in-position, following error and over-velocity.
// ----------------------------------------------------------------------------
module atm_monitor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  atm_pkg::tick_t   tick,
	input  atm_pkg::cfg_t    cfg,
	output atm_pkg::result_t result
);

	logic [16:0] ip_cnt_q, ip_cnt_d;
	logic [15:0] lag_cnt_q, lag_cnt_d;
	logic [16:0] os_traj_cnt_q, os_traj_cnt_d;
	logic [16:0] os_drv_cnt_q, os_drv_cnt_d;
	logic        os_latched_q, os_latched_d;

	logic [atm_pkg::MAG_W-1:0] err_mag, va_mag, vs_mag;
	logic [atm_pkg::CMP_W-1:0] err_x, va_x, vs_x;
	logic [15:0]               lag_twice;
	logic                      en, en_both, fast;

	always_comb begin
		err_mag   = atm_pkg::magnitude(tick.control_error);
		va_mag    = atm_pkg::magnitude(tick.velocity_actual);
		vs_mag    = atm_pkg::magnitude(tick.velocity_setpoint);
		err_x     = atm_pkg::CMP_W'(err_mag);
		va_x      = atm_pkg::CMP_W'(va_mag);
		vs_x      = atm_pkg::CMP_W'(vs_mag);
		lag_twice = {cfg.lag_cycles, 1'b0};
		en        = tick.axis_enabled;
		en_both   = tick.axis_enabled && tick.axis_enabled_prev;
		fast      = (va_x > atm_pkg::CMP_W'(cfg.velocity_limit)) ||
		            (vs_x > atm_pkg::CMP_W'(cfg.velocity_limit));

		ip_cnt_d      = ip_cnt_q;
		lag_cnt_d     = lag_cnt_q;
		os_traj_cnt_d = os_traj_cnt_q;
		os_drv_cnt_d  = os_drv_cnt_q;
		os_latched_d  = os_latched_q;
		result        = '0;

		if (tick.clear_monitor) begin
			ip_cnt_d      = '0;
			lag_cnt_d     = '0;
			os_traj_cnt_d = '0;
			os_drv_cnt_d  = '0;
			os_latched_d  = 1'b0;
		end else begin
			// In-position: error small and target reached for long enough.
			if (cfg.monitor_enables[atm_pkg::EN_IN_POS] && en) begin
				if ((err_x < atm_pkg::CMP_W'(cfg.in_position_tolerance)) &&
				    (tick.target_position_wrapped == tick.position_setpoint)) begin
					if (ip_cnt_q <= 17'(cfg.in_position_cycles)) begin
						ip_cnt_d = ip_cnt_q + 17'd1;
					end
					result.in_position = (ip_cnt_d > 17'(cfg.in_position_cycles));
				end else begin
					ip_cnt_d = '0;
				end
			end else begin
				result.in_position = 1'b1;
			end

			// Following error.
			if (cfg.monitor_enables[atm_pkg::EN_LAG]) begin
				if ((err_x > atm_pkg::CMP_W'(cfg.lag_tolerance)) && en_both) begin
					if (lag_cnt_q <= lag_twice) begin
						lag_cnt_d = lag_cnt_q + 16'd1;
					end
					result.lag_traj_interlock  = (lag_cnt_d > 16'(cfg.lag_cycles));
					result.lag_drive_interlock = (lag_cnt_d >= lag_twice);
				end else begin
					lag_cnt_d = '0;
				end
			end

			// Over-velocity: traj latch after a delay, drive flag after a further one.
			if (!en_both) begin
				os_latched_d  = 1'b0;
				os_traj_cnt_d = '0;
				os_drv_cnt_d  = '0;
			end else begin
				if (fast && cfg.monitor_enables[atm_pkg::EN_OVERSPEED]) begin
					if (os_traj_cnt_q <= 17'(cfg.overspeed_traj_delay)) begin
						os_traj_cnt_d = os_traj_cnt_q + 17'd1;
					end
				end else begin
					os_traj_cnt_d = '0;
				end
				if (!os_latched_q) begin
					os_latched_d = (os_traj_cnt_d >= 17'(cfg.overspeed_traj_delay));
				end
				// The drive counter wraps to zero once past its limit.
				if (os_latched_d && (os_drv_cnt_q <= 17'(cfg.overspeed_drive_delay))) begin
					os_drv_cnt_d = os_drv_cnt_q + 17'd1;
				end else begin
					os_drv_cnt_d = '0;
				end
				result.overspeed_traj_interlock  = os_latched_d;
				result.overspeed_drive_interlock = os_latched_d &&
					(os_drv_cnt_d >= 17'(cfg.overspeed_drive_delay));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_cnt_q      <= '0;
			lag_cnt_q     <= '0;
			os_traj_cnt_q <= '0;
			os_drv_cnt_q  <= '0;
			os_latched_q  <= 1'b0;
		end else if (step) begin
			ip_cnt_q      <= ip_cnt_d;
			lag_cnt_q     <= lag_cnt_d;
			os_traj_cnt_q <= os_traj_cnt_d;
			os_drv_cnt_q  <= os_drv_cnt_d;
			os_latched_q  <= os_latched_d;
		end
	end

endmodule

@@ hdl/axis_tolerance_time_monitor_top.sv @@
// ----------------------------------------------------------------------------
// Axis tolerance time monitor, top level
// The accepting edge loads the input register; the tick moves on into the
// result register when the input stage advances, which an output stall holds.
// Throughput: one request per cycle while out_stall is low; the monitor
// update is one short compare-and-count pass from input to result register.
// Reset: arst_n clears all counters, the overspeed latch and both valid bits
// at once, and loads the register defaults (enables 3, delays 200 and 400).
// ----------------------------------------------------------------------------
module axis_tolerance_time_monitor_top (
	input  logic                                  clk,
	input  logic                                  arst_n,

	// Configuration write port.
	input  logic                                  cfg_we,
	input  logic [atm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [atm_pkg::CFG_DATA_W-1:0]        cfg_data,

	// Input channel: one request is one control-cycle tick.
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  clear_monitor,
	input  logic                                  axis_enabled,
	input  logic                                  axis_enabled_prev,
	input  logic signed [atm_pkg::VALUE_WIDTH-1:0] control_error,
	input  logic signed [atm_pkg::VALUE_WIDTH-1:0] target_position_wrapped,
	input  logic signed [atm_pkg::VALUE_WIDTH-1:0] position_setpoint,
	input  logic signed [atm_pkg::VALUE_WIDTH-1:0] velocity_actual,
	input  logic signed [atm_pkg::VALUE_WIDTH-1:0] velocity_setpoint,

	// Output channel: one result request per tick.
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  in_position,
	output logic                                  lag_traj_interlock,
	output logic                                  lag_drive_interlock,
	output logic                                  overspeed_traj_interlock,
	output logic                                  overspeed_drive_interlock
);

	atm_pkg::cfg_t    cfg;
	atm_pkg::tick_t   tick_s1;
	atm_pkg::result_t result;
	atm_pkg::result_t result_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             advance;
	logic             accept;

	// The input stage moves on whenever the result register is empty or is
	// being drained this cycle. A new request is taken whenever the input
	// register is empty or moving on, so a waiting result never blocks the
	// input side as long as the input register is free.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	atm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register: payload has no reset, only its valid bit does.
	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1.clear_monitor           <= clear_monitor;
			tick_s1.axis_enabled            <= axis_enabled;
			tick_s1.axis_enabled_prev       <= axis_enabled_prev;
			tick_s1.control_error           <= control_error;
			tick_s1.target_position_wrapped <= target_position_wrapped;
			tick_s1.position_setpoint       <= position_setpoint;
			tick_s1.velocity_actual         <= velocity_actual;
			tick_s1.velocity_setpoint       <= velocity_setpoint;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// The monitor commits its counters exactly when the tick in the input
	// register moves into the result register, so each tick is counted once.
	atm_monitor u_monitor (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.tick   (tick_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	assign out_valid                 = out_valid_q;
	assign in_position               = result_q.in_position;
	assign lag_traj_interlock        = result_q.lag_traj_interlock;
	assign lag_drive_interlock       = result_q.lag_drive_interlock;
	assign overspeed_traj_interlock  = result_q.overspeed_traj_interlock;
	assign overspeed_drive_interlock = result_q.overspeed_drive_interlock;

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Axis tolerance time monitor testbench
// Sends control-cycle ticks through the valid/stall input channel and checks
// every result request against a cycle-free model of the three monitors.
// The model keeps its own register copy and counters. A short directed
// sequence comes first. Random phases follow, each with its own register
// setting: random values, all ones, all zeros but the enables. Both channels
// idle in random bursts, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
import atm_pkg::*;

class interlock_checker;
	cfg_t      regs;
	bit [16:0] inpos_cnt;
	bit [15:0] lag_cnt;
	bit [16:0] os_traj_cnt;
	bit [16:0] os_drive_cnt;
	bit        os_latched;
	result_t   expected_flags[$];
	int        mismatches;

	function new();
		regs = '0;
		regs.monitor_enables       = ENABLES_RST;
		regs.overspeed_traj_delay  = OS_TRAJ_DLY_RST;
		regs.overspeed_drive_delay = OS_DRV_DLY_RST;
		clear_counters();
		mismatches = 0;
	endfunction

	function void clear_counters();
		inpos_cnt    = '0;
		lag_cnt      = '0;
		os_traj_cnt  = '0;
		os_drive_cnt = '0;
		os_latched   = 1'b0;
	endfunction

	// Bits above a register's width are dropped, as in the block.
	function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_MONITOR_ENABLES:       regs.monitor_enables       = data[2:0];
			REG_IN_POSITION_TOLERANCE: regs.in_position_tolerance = data[30:0];
			REG_IN_POSITION_CYCLES:    regs.in_position_cycles    = data[15:0];
			REG_LAG_TOLERANCE:         regs.lag_tolerance         = data[30:0];
			REG_LAG_CYCLES:            regs.lag_cycles            = data[14:0];
			REG_VELOCITY_LIMIT:        regs.velocity_limit        = data[30:0];
			REG_OVERSPEED_TRAJ_DELAY:  regs.overspeed_traj_delay  = data[15:0];
			REG_OVERSPEED_DRIVE_DELAY: regs.overspeed_drive_delay = data[15:0];
			default: ;
		endcase
	endfunction

	// Absolute value; the most negative code counts as the largest positive one.
	function bit [VALUE_WIDTH-1:0] saturated_magnitude(logic [VALUE_WIDTH-1:0] v);
		bit [VALUE_WIDTH-1:0] u;
		u = v;
		if (u[VALUE_WIDTH-1])
			u = ~u + 1'b1;
		if (u[VALUE_WIDTH-1])
			u = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
		return u;
	endfunction

	function void note_tick(tick_t t);
		bit [VALUE_WIDTH-1:0] err_mag;
		bit [15:0]            lag_twice;
		bit                   fast;
		bit                   en_both;
		result_t              flags;
		flags = '0;
		if (t.clear_monitor) begin
			clear_counters();
			expected_flags.push_back(flags);
			return;
		end
		err_mag = saturated_magnitude(t.control_error);
		en_both = t.axis_enabled && t.axis_enabled_prev;

		if (regs.monitor_enables[EN_IN_POS] && t.axis_enabled) begin
			if (err_mag < regs.in_position_tolerance &&
					t.target_position_wrapped == t.position_setpoint) begin
				if (inpos_cnt <= regs.in_position_cycles)
					inpos_cnt++;
				flags.in_position = (inpos_cnt > regs.in_position_cycles);
			end else begin
				inpos_cnt = '0;
			end
		end else begin
			flags.in_position = 1'b1;
		end

		if (regs.monitor_enables[EN_LAG]) begin
			lag_twice = {regs.lag_cycles, 1'b0};
			if (err_mag > regs.lag_tolerance && en_both) begin
				if (lag_cnt <= lag_twice)
					lag_cnt++;
				flags.lag_traj_interlock  = (lag_cnt > regs.lag_cycles);
				flags.lag_drive_interlock = (lag_cnt >= lag_twice);
			end else begin
				lag_cnt = '0;
			end
		end

		if (!en_both) begin
			os_latched   = 1'b0;
			os_traj_cnt  = '0;
			os_drive_cnt = '0;
		end else begin
			fast = saturated_magnitude(t.velocity_actual) > regs.velocity_limit ||
				saturated_magnitude(t.velocity_setpoint) > regs.velocity_limit;
			if (fast && regs.monitor_enables[EN_OVERSPEED]) begin
				if (os_traj_cnt <= regs.overspeed_traj_delay)
					os_traj_cnt++;
			end else begin
				os_traj_cnt = '0;
			end
			if (!os_latched)
				os_latched = (os_traj_cnt >= regs.overspeed_traj_delay);
			// The drive counter wraps to zero one tick after passing its delay.
			if (os_latched && os_drive_cnt <= regs.overspeed_drive_delay)
				os_drive_cnt++;
			else
				os_drive_cnt = '0;
			flags.overspeed_drive_interlock =
				os_latched && (os_drive_cnt >= regs.overspeed_drive_delay);
		end
		flags.overspeed_traj_interlock = os_latched;
		expected_flags.push_back(flags);
	endfunction

	function void compare_flag(string name, logic want, logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			mismatches++;
		end
	endfunction

	function void check_flags(result_t got);
		result_t want;
		if (expected_flags.size() == 0) begin
			$error("result request with no tick outstanding");
			mismatches++;
			return;
		end
		want = expected_flags.pop_front();
		compare_flag("in_position", want.in_position, got.in_position);
		compare_flag("lag_traj_interlock", want.lag_traj_interlock,
			got.lag_traj_interlock);
		compare_flag("lag_drive_interlock", want.lag_drive_interlock,
			got.lag_drive_interlock);
		compare_flag("overspeed_traj_interlock", want.overspeed_traj_interlock,
			got.overspeed_traj_interlock);
		compare_flag("overspeed_drive_interlock", want.overspeed_drive_interlock,
			got.overspeed_drive_interlock);
	endfunction

	function int outstanding();
		return expected_flags.size();
	endfunction
endclass

module tb_top;

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 80;

	bit clk;
	logic arst_n = 1'b0;

	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic  in_valid = 1'b0;
	logic  in_stall;
	tick_t req = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic in_position;
	logic lag_traj_interlock;
	logic lag_drive_interlock;
	logic overspeed_traj_interlock;
	logic overspeed_drive_interlock;

	bit src_idle_on = 1'b1;
	bit rx_idle_on  = 1'b1;
	bit rx_hold_req = 1'b0;
	int rx_left     = 0;
	int quiet_cycles = 0;

	interlock_checker sb = new();

	axis_tolerance_time_monitor_top dut (
		.clk                       (clk),
		.arst_n                    (arst_n),
		.cfg_we                    (cfg_we),
		.cfg_index                 (cfg_index),
		.cfg_data                  (cfg_data),
		.in_valid                  (in_valid),
		.in_stall                  (in_stall),
		.clear_monitor             (req.clear_monitor),
		.axis_enabled              (req.axis_enabled),
		.axis_enabled_prev         (req.axis_enabled_prev),
		.control_error             (req.control_error),
		.target_position_wrapped   (req.target_position_wrapped),
		.position_setpoint         (req.position_setpoint),
		.velocity_actual           (req.velocity_actual),
		.velocity_setpoint         (req.velocity_setpoint),
		.out_valid                 (out_valid),
		.out_stall                 (out_stall),
		.in_position               (in_position),
		.lag_traj_interlock        (lag_traj_interlock),
		.lag_drive_interlock       (lag_drive_interlock),
		.overspeed_traj_interlock  (overspeed_traj_interlock),
		.overspeed_drive_interlock (overspeed_drive_interlock)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every accepted tick feeds the model; every accepted result is checked.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_stall === 1'b0)
			sb.note_tick(req);
		if (arst_n && out_valid === 1'b1 && !out_stall)
			sb.check_flags(result_t'({in_position, lag_traj_interlock,
				lag_drive_interlock, overspeed_traj_interlock,
				overspeed_drive_interlock}));
	end

	// Receiver: short random stall bursts, plus one long hold on request.
	always @(negedge clk) begin
		if (rx_left > 0) begin
			rx_left--;
			out_stall <= 1'b1;
		end else if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
			rx_left = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog on cycles with no handshake on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, int width, logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] keep;
		logic [CFG_DATA_W-1:0] data;
		keep = {CFG_DATA_W{1'b1}} >> (CFG_DATA_W - width);
		data = (CFG_DATA_W'($urandom) & ~keep) | (value & keep);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic load_config(cfg_t c);
		write_reg(REG_MONITOR_ENABLES, $bits(c.monitor_enables), c.monitor_enables);
		write_reg(REG_IN_POSITION_TOLERANCE, $bits(c.in_position_tolerance),
			c.in_position_tolerance);
		write_reg(REG_IN_POSITION_CYCLES, $bits(c.in_position_cycles),
			c.in_position_cycles);
		write_reg(REG_LAG_TOLERANCE, $bits(c.lag_tolerance), c.lag_tolerance);
		write_reg(REG_LAG_CYCLES, $bits(c.lag_cycles), c.lag_cycles);
		write_reg(REG_VELOCITY_LIMIT, $bits(c.velocity_limit), c.velocity_limit);
		write_reg(REG_OVERSPEED_TRAJ_DELAY, $bits(c.overspeed_traj_delay),
			c.overspeed_traj_delay);
		write_reg(REG_OVERSPEED_DRIVE_DELAY, $bits(c.overspeed_drive_delay),
			c.overspeed_drive_delay);
	endtask

	task automatic send_tick(tick_t t);
		int gap;
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req      <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// Stop sending and wait until every tick has produced its result.
	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic tick_t mk(bit clr, bit en, bit en_prev, logic [31:0] err,
			logic [31:0] tgt, logic [31:0] sp, logic [31:0] va, logic [31:0] vs);
		tick_t t;
		t.clear_monitor           = clr;
		t.axis_enabled            = en;
		t.axis_enabled_prev       = en_prev;
		t.control_error           = err;
		t.target_position_wrapped = tgt;
		t.position_setpoint       = sp;
		t.velocity_actual         = va;
		t.velocity_setpoint       = vs;
		return t;
	endfunction

	// A value whose magnitude lies within lo..hi of a bound, with random sign.
	function automatic logic [VALUE_WIDTH-1:0] near_value(logic [30:0] bound,
			int lo, int hi);
		longint m;
		m = longint'(bound) + longint'($urandom_range(hi - lo, 0)) + longint'(lo);
		if (m < 0)
			m = 0;
		if (m > 64'sh8000_0000)
			m = 64'sh8000_0000;
		if ($urandom_range(0, 1))
			m = -m;
		return m[VALUE_WIDTH-1:0];
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		c.monitor_enables = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : 3'd7;
		c.in_position_tolerance = $urandom_range(0, 1) ? 31'($urandom)
			: 31'($urandom_range(0, 1024));
		c.in_position_cycles = 16'($urandom_range(0, 8));
		c.lag_tolerance = $urandom_range(0, 1) ? 31'($urandom)
			: 31'($urandom_range(0, 1024));
		c.lag_cycles = 15'($urandom_range(0, 6));
		c.velocity_limit = $urandom_range(0, 1) ? 31'($urandom)
			: 31'($urandom_range(0, 1024));
		c.overspeed_traj_delay  = 16'($urandom_range(0, 5));
		c.overspeed_drive_delay = 16'($urandom_range(0, 5));
		return c;
	endfunction

	// Random ticks come in segments that hold one kind of behavior, so that the
	// timed monitors see long enough runs to reach their later states.
	task automatic run_random(int count);
		int    seg_left = 0;
		int    err_mode = 0;
		int    vel_mode = 0;
		int    en_mode  = 0;
		bit    pos_match = 1'b1;
		tick_t t;
		for (int i = 0; i < count; i++) begin
			if (seg_left == 0) begin
				seg_left  = $urandom_range(3, 25);
				err_mode  = $urandom_range(0, 3);
				vel_mode  = $urandom_range(0, 2);
				en_mode   = $urandom_range(0, 3);
				pos_match = ($urandom_range(0, 4) != 0);
			end
			seg_left--;
			t.clear_monitor = ($urandom_range(0, 49) == 0);
			if (en_mode == 0) begin
				t.axis_enabled      = 1'($urandom_range(0, 1));
				t.axis_enabled_prev = 1'($urandom_range(0, 1));
			end else begin
				t.axis_enabled      = ($urandom_range(0, 39) != 0);
				t.axis_enabled_prev = ($urandom_range(0, 39) != 0);
			end
			case (err_mode)
				0: t.control_error = $urandom;
				1: t.control_error = ($urandom_range(0, 7) == 0)
					? near_value(sb.regs.in_position_tolerance, -1, 1)
					: near_value(sb.regs.in_position_tolerance, -4, -1);
				2: t.control_error = ($urandom_range(0, 7) == 0)
					? near_value(sb.regs.lag_tolerance, -1, 1)
					: near_value(sb.regs.lag_tolerance, 1, 4);
				default: begin
					case ($urandom_range(0, 4))
						0: t.control_error = 32'h8000_0000;
						1: t.control_error = 32'h7FFF_FFFF;
						2: t.control_error = 32'hFFFF_FFFF;
						3: t.control_error = 32'h0000_0001;
						default: t.control_error = '0;
					endcase
				end
			endcase
			t.target_position_wrapped = $urandom;
			if (pos_match)
				t.position_setpoint = t.target_position_wrapped;
			else if ($urandom_range(0, 1))
				t.position_setpoint = $urandom;
			else
				t.position_setpoint = t.target_position_wrapped ^
					(32'd1 << $urandom_range(0, 31));
			case (vel_mode)
				0: begin
					t.velocity_actual   = $urandom;
					t.velocity_setpoint = $urandom;
				end
				1: begin
					t.velocity_actual   = near_value(sb.regs.velocity_limit, -3, 0);
					t.velocity_setpoint = near_value(sb.regs.velocity_limit, -3, 0);
				end
				default: begin
					t.velocity_actual   = near_value(sb.regs.velocity_limit, 1, 3);
					t.velocity_setpoint = $urandom_range(0, 1)
						? near_value(sb.regs.velocity_limit, -3, 3) : $urandom;
				end
			endcase
			send_tick(t);
		end
	endtask

	initial begin
		cfg_t c;

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Reset register values: in-position and lag on, zero tolerances.
		send_tick(mk(0, 0, 0, 32'h0000_0005, 32'h10, 32'h10, 0, 0));
		send_tick(mk(0, 1, 1, 32'h0000_0005, 32'h10, 32'h10, 0, 0));
		send_tick(mk(0, 1, 1, 32'h8000_0000, 32'h10, 32'h10, 32'h8000_0000, 0));
		drain();

		c = '0;
		c.monitor_enables       = 3'd7;
		c.in_position_tolerance = 31'h100;
		c.in_position_cycles    = 16'd2;
		c.lag_tolerance         = 31'h100;
		c.lag_cycles            = 15'd2;
		c.velocity_limit        = 31'h1000;
		c.overspeed_traj_delay  = 16'd2;
		c.overspeed_drive_delay = 16'd1;
		load_config(c);

		send_tick(mk(1, 1'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
			$urandom, $urandom));
		// Small error held at the target: in-position after more than 2 ticks.
		repeat (3) send_tick(mk(0, 1, 1, 32'h10, 32'h1234, 32'h1234, 0, 0));
		// Large errors, the most negative one saturating, build up the lag flags.
		send_tick(mk(0, 1, 1, 32'h8000_0000, 32'h1234, 32'h1234, 0, 0));
		send_tick(mk(0, 1, 1, 32'h7FFF_FFFF, 32'h1234, 32'h1234, 0, 0));
		send_tick(mk(0, 1, 1, 32'hFFFF_FEFF, 32'h1234, 32'h1234, 0, 0));
		send_tick(mk(0, 1, 1, 32'h0000_0101, 32'h1234, 32'h1234, 0, 0));
		send_tick(mk(0, 1, 1, 32'h0000_0100, 32'h1234, 32'h1234, 0, 0));
		// Axis disabled now, then enabled but not in the cycle before.
		send_tick(mk(0, 0, 1, 32'h0, 32'h1234, 32'h1234, 32'h8000_0000, 0));
		send_tick(mk(0, 1, 0, 32'h0, 32'h1234, 32'h1234, 32'h8000_0000, 0));
		// Sustained overspeed: latch, drive flag, then the drive counter wraps.
		repeat (5) send_tick(mk(0, 1, 1, 32'h0, 32'h1234, 32'h1234, 32'h8000_0000, 0));
		send_tick(mk(0, 1, 1, 32'h0, 32'h1234, 32'h1234, 32'h1000, 32'hFFFF_EFFF));
		send_tick(mk(0, 1, 1, 32'h0, 32'h1234, 32'h1234, 32'h1000, 32'hFFFF_F000));
		send_tick(mk(0, 1, 1, 32'h10, 32'h1234, 32'h1235, 0, 0));
		drain();

		// Overspeed monitor switched off while latched: the latch must stay.
		write_reg(REG_MONITOR_ENABLES, 3, 3'd3);
		repeat (2) send_tick(mk(0, 1, 1, 32'h0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
		send_tick(mk(0, 1, 0, 32'h0, 0, 0, 32'h8000_0000, 0));
		drain();
		// In-position and lag monitors both off.
		write_reg(REG_MONITOR_ENABLES, 3, 3'd4);
		send_tick(mk(0, 1, 1, 32'h8000_0000, 0, 32'h5, 32'h8000_0000, 0));
		send_tick(mk(1, 1, 1, 32'h8000_0000, 0, 32'h5, 32'h8000_0000, 0));
		drain();

		for (int p = 0; p < 7; p++) begin
			c = random_config();
			if (p == 1) begin
				c = '1;
			end else if (p == 2) begin
				c = '0;
				c.monitor_enables = 3'd7;
			end
			if (p == 6) begin
				src_idle_on = 1'b0;
				rx_idle_on  = 1'b0;
			end
			load_config(c);
			if (p == 3)
				rx_hold_req = 1'b1;
			run_random(50);
			if (p == 4)
				drain();
			run_random(50);
			drain();
		end

		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
